// ===== rtl/jsp_pkg.sv =====
package jsp_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SET     = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;
    localparam logic [1:0] ACT_REPLY   = 2'd3;

    localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] CFG_ENABLE_MASK = 2'd2;

    localparam logic [15:0] STEP_SIZE_RESET = 16'd30;
    localparam logic [15:0] MAX_SPEED_RESET = 16'd30;
    localparam logic [6:0]  ENABLE_RESET    = 7'd126;

    localparam logic [7:0]  OP_POSITION  = 8'hA4;
    localparam logic [7:0]  OP_READ      = 8'h92;
    localparam logic [10:0] REPLY_OFFSET = 11'h100;

    // 18000/pi in Q16, rounded
    localparam logic [28:0] CDEG_PER_RAD_Q16 = 29'd375493621;

    localparam int MASK_W = 7;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         joint;
        logic signed [31:0] rel_angle_rad;
        logic [10:0]        reply_can_id;
        logic [7:0]         reply_opcode;
        logic signed [31:0] reply_angle;
    } req_t;

    typedef struct packed {
        logic [10:0]        dest_id;
        logic [7:0]         command_code;
        logic [15:0]        speed_limit;
        logic signed [31:0] command_angle;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] initial_angle;
        logic signed [31:0] target_angle;
        logic signed [31:0] current_angle;
    } entry_t;

    function automatic logic [10:0] dest_id_of(input logic [3:0] j);
        logic [10:0] id;
        begin
            case (j)
                4'd0:    id = 11'h141;
                4'd1:    id = 11'h142;
                4'd2:    id = 11'h144;
                4'd3:    id = 11'h145;
                4'd4:    id = 11'h146;
                4'd5:    id = 11'h147;
                4'd6:    id = 11'h148;
                4'd7:    id = 11'h149;
                4'd8:    id = 11'h14A;
                4'd9:    id = 11'h14B;
                4'd10:   id = 11'h14C;
                4'd11:   id = 11'h14D;
                4'd12:   id = 11'h14E;
                4'd13:   id = 11'h14F;
                4'd14:   id = 11'h150;
                default: id = 11'h151;
            endcase
            return id;
        end
    endfunction

endpackage

// ===== rtl/jsp_ram.sv =====
module jsp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 7,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/jsp_store.sv =====
module jsp_store #(
    parameter int NUM_JOINTS = 7,
    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  jsp_pkg::entry_t   wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output jsp_pkg::entry_t   rdata
);

    localparam int EW = $bits(jsp_pkg::entry_t);

    logic [NUM_JOINTS-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [EW-1:0]         ram_q;

    jsp_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_JOINTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? jsp_pkg::entry_t'(ram_q) : '0;

endmodule

// ===== rtl/jsp_arith.sv =====
module jsp_arith (
    input  jsp_pkg::entry_t    entry,
    input  logic [15:0]        step_size,
    input  logic [28:0]        cdeg_mag,
    input  logic               cdeg_neg,
    output logic signed [31:0] slew_angle,
    output logic signed [31:0] set_angle
);

    logic signed [32:0] err;
    logic signed [32:0] step_s;
    logic signed [32:0] cur_s;
    logic signed [32:0] cdeg;
    logic signed [32:0] sum;

    always_comb
    begin
        cur_s  = 33'(entry.current_angle);
        step_s = $signed({17'b0, step_size});
        err    = 33'(entry.target_angle) - cur_s;
        // a step never passes the target, so no overflow here
        if (err > step_s)
        begin
            slew_angle = 32'(cur_s + step_s);
        end
        else if (err < -step_s)
        begin
            slew_angle = 32'(cur_s - step_s);
        end
        else
        begin
            slew_angle = entry.target_angle;
        end

        cdeg = cdeg_neg ? -$signed({4'b0, cdeg_mag}) : $signed({4'b0, cdeg_mag});
        sum  = 33'(entry.initial_angle) + cdeg;
        if (sum > 33'sh0_7FFF_FFFF)
        begin
            set_angle = 32'sh7FFF_FFFF;
        end
        else if (sum < -33'sh0_8000_0000)
        begin
            set_angle = -32'sh8000_0000;
        end
        else
        begin
            set_angle = 32'(sum);
        end
    end

endmodule

// ===== rtl/joint_slew_position_commander.sv =====
// Seven-channel (NUM_JOINTS) slew-rate position commander. Transactions are taken one at a
// time; req_ready is high only while the block is idle, and the output register lets a
// result wait on rsp_ready while the next transaction is taken. A tick is accepted, then
// visits each joint in turn: an enabled joint is read, then modified and written back
// (through the single read port of the joint state memory), a disabled joint is skipped,
// and an output stall holds the write. A request visits each joint in turn; a set target
// reads the joint and does the 32x29 multiply, then adds and writes; an angle reply
// writes a matching joint. Joint state reads as zero after reset; there is no clearing pass.
module joint_slew_position_commander #(
    parameter int NUM_JOINTS = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            req_valid,
    output logic            req_ready,
    input  jsp_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output jsp_pkg::rsp_t   rsp
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [JW-1:0] LAST_J = JW'(NUM_JOINTS - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_TICK_RD = 3'd1;
    localparam logic [2:0] S_TICK_WR = 3'd2;
    localparam logic [2:0] S_REQ     = 3'd3;
    localparam logic [2:0] S_SET_RD  = 3'd4;
    localparam logic [2:0] S_SET_WR  = 3'd5;
    localparam logic [2:0] S_REPLY   = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [JW-1:0]   j_reg, j_next;
    jsp_pkg::req_t   req_reg;
    logic [15:0]     step_size_reg;
    logic [15:0]     max_speed_reg;
    logic [6:0]      mask_reg;
    logic [28:0]     cdeg_reg, cdeg_next;
    logic            neg_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    jsp_pkg::rsp_t   rsp_reg, rsp_next;

    logic                  mem_we, mem_re;
    logic [JW-1:0]         mem_waddr, mem_raddr;
    jsp_pkg::entry_t       mem_wdata, mem_rdata;
    logic signed [31:0]    slew_angle, set_angle;

    logic [NUM_JOINTS-1:0] en_vec;
    logic [NUM_JOINTS-1:0] above_vec;
    logic [15:0]           mask_wide;
    logic                  is_last;
    logic                  out_free;
    logic                  reply_hit;
    logic [JW-1:0]         reply_j;
    logic [31:0]           rel_mag;
    logic [60:0]           product;

    jsp_store #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    jsp_arith u_arith (
        .entry      (mem_rdata),
        .step_size  (step_size_reg),
        .cdeg_mag   (cdeg_reg),
        .cdeg_neg   (neg_reg),
        .slew_angle (slew_angle),
        .set_angle  (set_angle)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        mask_wide = 16'(mask_reg);
        reply_hit = 1'b0;
        reply_j   = '0;
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            en_vec[i]    = (i < jsp_pkg::MASK_W) && mask_wide[i];
            above_vec[i] = en_vec[i] && (i > int'(j_reg));
            if (!reply_hit && (req_reg.reply_can_id ==
                jsp_pkg::dest_id_of(4'(i)) + jsp_pkg::REPLY_OFFSET))
            begin
                reply_hit = 1'b1;
                reply_j   = JW'(i);
            end
        end
        is_last = ~|above_vec;
        rel_mag = req_reg.rel_angle_rad[31] ? 32'(-req_reg.rel_angle_rad)
                                            : 32'(req_reg.rel_angle_rad);
        product = 61'(rel_mag) * 61'(jsp_pkg::CDEG_PER_RAD_Q16);
    end

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        cdeg_next      = cdeg_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = j_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = j_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                j_next = '0;
                if (req_valid)
                begin
                    unique case (req.action)
                        jsp_pkg::ACT_TICK:    state_next = S_TICK_RD;
                        jsp_pkg::ACT_SET:     state_next = S_SET_RD;
                        jsp_pkg::ACT_REQUEST: state_next = S_REQ;
                        default:              state_next = S_REPLY;
                    endcase
                end
            end
            S_TICK_RD:
            begin
                if (en_vec[j_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_TICK_WR;
                end
                else if (j_reg == LAST_J)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_TICK_WR:
            begin
                if (out_free)
                begin
                    mem_we                  = 1'b1;
                    mem_wdata.current_angle = slew_angle;
                    rsp_valid_next          = 1'b1;
                    rsp_next.dest_id        = jsp_pkg::dest_id_of(4'(j_reg));
                    rsp_next.command_code   = jsp_pkg::OP_POSITION;
                    rsp_next.speed_limit    = max_speed_reg;
                    rsp_next.command_angle  = slew_angle;
                    rsp_next.last           = is_last;
                    if (j_reg == LAST_J)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_TICK_RD;
                    end
                end
            end
            S_REQ:
            begin
                if (!en_vec[j_reg] || out_free)
                begin
                    if (en_vec[j_reg])
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.dest_id       = jsp_pkg::dest_id_of(4'(j_reg));
                        rsp_next.command_code  = jsp_pkg::OP_READ;
                        rsp_next.speed_limit   = '0;
                        rsp_next.command_angle = '0;
                        rsp_next.last          = is_last;
                    end
                    if (j_reg == LAST_J)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            S_SET_RD:
            begin
                if (5'(req_reg.joint) < 5'(NUM_JOINTS))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = JW'(req_reg.joint);
                    cdeg_next  = product[60:32];
                    state_next = S_SET_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SET_WR:
            begin
                mem_we                 = 1'b1;
                mem_waddr              = JW'(req_reg.joint);
                mem_wdata.target_angle = set_angle;
                state_next             = S_IDLE;
            end
            S_REPLY:
            begin
                if (req_reg.reply_opcode == jsp_pkg::OP_READ && reply_hit)
                begin
                    mem_we                  = 1'b1;
                    mem_waddr               = reply_j;
                    mem_wdata.initial_angle = req_reg.reply_angle;
                    mem_wdata.target_angle  = req_reg.reply_angle;
                    mem_wdata.current_angle = req_reg.reply_angle;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            step_size_reg <= jsp_pkg::STEP_SIZE_RESET;
            max_speed_reg <= jsp_pkg::MAX_SPEED_RESET;
            mask_reg      <= jsp_pkg::ENABLE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jsp_pkg::CFG_STEP_SIZE:   step_size_reg <= cfg_data;
                    jsp_pkg::CFG_MAX_SPEED:   max_speed_reg <= cfg_data;
                    jsp_pkg::CFG_ENABLE_MASK: mask_reg      <= cfg_data[6:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        cdeg_reg <= cdeg_next;
        if (req_valid && req_ready)
        begin
            req_reg <= req;
            neg_reg <= req.rel_angle_rad[31];
        end
    end

endmodule

// ===== rtl/jsp_checker.sv =====
module jsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input jsp_pkg::rsp_t rsp
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("transaction taken while busy");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.command_code == jsp_pkg::OP_POSITION ||
                       rsp.command_code == jsp_pkg::OP_READ))
        else $error("unknown command code");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.command_code == jsp_pkg::OP_READ |->
            rsp.speed_limit == '0 && rsp.command_angle == '0)
        else $error("read command with speed or angle");

endmodule

bind joint_slew_position_commander jsp_checker u_jsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/tb_joint_slew_position_commander.sv =====
`timescale 1ns / 100ps

module tb_joint_slew_position_commander;

    localparam int N_JOINTS      = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [15:0]   cfg_data;
    logic          req_valid;
    logic          req_ready;
    jsp_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    jsp_pkg::rsp_t rsp;

    joint_slew_position_commander u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predictor state
    logic [15:0]        step_sz;
    logic [15:0]        speed_lim;
    logic [6:0]         en_mask;
    logic signed [31:0] init_ang [N_JOINTS];
    logic signed [31:0] tgt_ang  [N_JOINTS];
    logic signed [31:0] cur_ang  [N_JOINTS];
    jsp_pkg::rsp_t      expected_cmds [$];

    int          errors;
    int          requests_sent;
    int          cmds_checked;
    int          reg_writes;
    int          burst_left;
    bit          sender_gaps;
    stall_mode_t stall_mode;
    int          holdoff_req;
    int          holdoff_left;
    logic [15:0] ready_pat;
    int          pat_count;

    always #5 clk = ~clk;

    function automatic logic [10:0] can_id_of(input int j);
        logic [10:0] id;
        begin
            case (j)
                0:       id = 11'h141;
                1:       id = 11'h142;
                2:       id = 11'h144;
                3:       id = 11'h145;
                4:       id = 11'h146;
                5:       id = 11'h147;
                default: id = 11'h148;
            endcase
            return id;
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        begin
            if (v > S32_MAX)
            begin
                return 32'sh7fffffff;
            end
            if (v < S32_MIN)
            begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

    function automatic jsp_pkg::req_t make_req(input logic [1:0] action,
                                               input logic [2:0] joint,
                                               input logic [31:0] rel, input logic [10:0] id,
                                               input logic [7:0] opc,
                                               input logic [31:0] angle);
        jsp_pkg::req_t r;
        begin
            r.action        = action;
            r.joint         = joint;
            r.rel_angle_rad = rel;
            r.reply_can_id  = id;
            r.reply_opcode  = opc;
            r.reply_angle   = angle;
            return r;
        end
    endfunction

    function automatic logic [15:0] pick_limit();
        logic [15:0] v;
        begin
            case ($urandom_range(0, 4))
                0:       v = 16'd0;
                1:       v = 16'hffff;
                2:       v = 16'($urandom_range(1, 64));
                default: v = 16'($urandom_range(0, 65535));
            endcase
            return v;
        end
    endfunction

    function automatic jsp_pkg::req_t random_req();
        jsp_pkg::req_t r;
        int unsigned   pick;
        int            j;
        begin
            r = make_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom,
                         11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)), $urandom);
            pick = $urandom_range(0, 99);
            j = $urandom_range(0, N_JOINTS - 1);
            if (pick < 35)
            begin
                r.action = jsp_pkg::ACT_TICK;
            end
            else if (pick < 60)
            begin
                r.action = jsp_pkg::ACT_SET;
                r.joint  = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'(j);
                if ($urandom_range(0, 1) == 0)
                begin
                    r.rel_angle_rad = 32'($urandom_range(0, 262143)) - 32'd131072;
                end
            end
            else if (pick < 70)
            begin
                r.action = jsp_pkg::ACT_REQUEST;
            end
            else if (pick < 90)
            begin
                r.action       = jsp_pkg::ACT_REPLY;
                r.reply_opcode = jsp_pkg::OP_READ;
                r.reply_can_id = can_id_of(j) + jsp_pkg::REPLY_OFFSET;
                if ($urandom_range(0, 1) == 0)
                begin
                    r.reply_angle = 32'($urandom_range(0, 200000)) - 32'd100000;
                end
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic push_cmd(input int j, input logic [7:0] code, input logic [15:0] speed,
                            input logic signed [31:0] angle);
        jsp_pkg::rsp_t c;
        begin
            c.dest_id       = can_id_of(j);
            c.command_code  = code;
            c.speed_limit   = speed;
            c.command_angle = angle;
            c.last          = 1'b0;
            expected_cmds.push_back(c);
        end
    endtask

    task automatic predict_joint_commands(input jsp_pkg::req_t r);
        int          n;
        longint      err;
        longint      st;
        longint      rel;
        longint unsigned mag;
        longint      cdeg;
        begin
            n = 0;
            case (r.action)
                jsp_pkg::ACT_TICK:
                begin
                    st = longint'(step_sz);
                    for (int j = 0; j < N_JOINTS; j++)
                    begin
                        if (en_mask[j])
                        begin
                            err = longint'(tgt_ang[j]) - longint'(cur_ang[j]);
                            if (err > st)
                            begin
                                cur_ang[j] = clamp32(longint'(cur_ang[j]) + st);
                            end
                            else if (err < -st)
                            begin
                                cur_ang[j] = clamp32(longint'(cur_ang[j]) - st);
                            end
                            else
                            begin
                                cur_ang[j] = tgt_ang[j];
                            end
                            push_cmd(j, jsp_pkg::OP_POSITION, speed_lim, cur_ang[j]);
                            n++;
                        end
                    end
                end
                jsp_pkg::ACT_SET:
                begin
                    if (r.joint < N_JOINTS)
                    begin
                        rel  = longint'($signed(r.rel_angle_rad));
                        mag  = (rel < 0) ? longint'(-rel) : rel;
                        cdeg = longint'((mag * 64'(jsp_pkg::CDEG_PER_RAD_Q16)) >> 32);
                        if (rel < 0)
                        begin
                            cdeg = -cdeg;
                        end
                        tgt_ang[r.joint] = clamp32(longint'(init_ang[r.joint]) + cdeg);
                    end
                end
                jsp_pkg::ACT_REQUEST:
                begin
                    for (int j = 0; j < N_JOINTS; j++)
                    begin
                        if (en_mask[j])
                        begin
                            push_cmd(j, jsp_pkg::OP_READ, 16'd0, 32'sd0);
                            n++;
                        end
                    end
                end
                default:
                begin
                    if (r.reply_opcode == jsp_pkg::OP_READ)
                    begin
                        for (int j = 0; j < N_JOINTS; j++)
                        begin
                            if (r.reply_can_id == can_id_of(j) + jsp_pkg::REPLY_OFFSET)
                            begin
                                init_ang[j] = r.reply_angle;
                                tgt_ang[j]  = r.reply_angle;
                                cur_ang[j]  = r.reply_angle;
                                break;
                            end
                        end
                    end
                end
            endcase
            if (n > 0)
            begin
                expected_cmds[expected_cmds.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic check_command(input jsp_pkg::rsp_t got);
        jsp_pkg::rsp_t want;
        begin
            if (expected_cmds.size() == 0)
            begin
                report_mismatch("command with none pending, id", got.dest_id, 0);
                return;
            end
            want = expected_cmds.pop_front();
            cmds_checked++;
            if (got.dest_id !== want.dest_id)
                report_mismatch("dest_id", got.dest_id, want.dest_id);
            if (got.command_code !== want.command_code)
                report_mismatch("command_code", got.command_code, want.command_code);
            if (got.speed_limit !== want.speed_limit)
                report_mismatch("speed_limit", got.speed_limit, want.speed_limit);
            if (got.command_angle !== want.command_angle)
                report_mismatch("command_angle", got.command_angle, want.command_angle);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    // receiver: check each transaction, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            check_command(rsp);
        end
        if (holdoff_req != 0)
        begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (pat_count == 0)
            begin
                case (stall_mode)
                    STALL_NONE:  ready_pat = 16'hffff;
                    STALL_LIGHT: ready_pat = 16'($urandom | $urandom);
                    default:     ready_pat = 16'($urandom & $urandom);
                endcase
                pat_count = 16;
            end
            rsp_ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            pat_count--;
        end
    end

    task automatic push_request(input jsp_pkg::req_t r);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = (sender_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 9) : 0;
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 10);
            end
            req_valid <= 1'b1;
            req       <= r;
            @(posedge clk);
            while (!req_ready)
            begin
                @(posedge clk);
            end
            predict_joint_commands(r);
            requests_sent++;
            burst_left--;
        end
    endtask

    task automatic wait_for_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (expected_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            jsp_pkg::CFG_STEP_SIZE:   step_sz   = val;
            jsp_pkg::CFG_MAX_SPEED:   speed_lim = val;
            jsp_pkg::CFG_ENABLE_MASK: en_mask   = val[6:0];
            default:                  ;
        endcase
        reg_writes++;
    endtask

    task automatic program_limits(input logic [15:0] step, input logic [15:0] speed,
                                  input logic [6:0] mask);
        write_reg(jsp_pkg::CFG_STEP_SIZE, step);
        write_reg(jsp_pkg::CFG_MAX_SPEED, speed);
        write_reg(jsp_pkg::CFG_ENABLE_MASK, {9'($urandom_range(0, 511)), mask});
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_REQUEST, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
    endtask

    task automatic test_target_conversion();
        push_request(make_req(jsp_pkg::ACT_SET, 3'd1, 32'h7fffffff, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd2, 32'h80000000, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd3, 32'hffffffff, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd4, 32'h00010000, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd5, 32'hfffe8000, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd7, 32'h00010000, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
    endtask

    task automatic test_reply_seeding();
        push_request(make_req(jsp_pkg::ACT_REPLY, 3'd0, 32'd0, 11'h241, jsp_pkg::OP_READ,
                              32'h7fffffff));
        push_request(make_req(jsp_pkg::ACT_REPLY, 3'd0, 32'd0, 11'h248, jsp_pkg::OP_READ,
                              32'h80000000));
        push_request(make_req(jsp_pkg::ACT_REPLY, 3'd0, 32'd0, 11'h242, 8'h93, 32'd5));
        push_request(make_req(jsp_pkg::ACT_REPLY, 3'd0, 32'd0, 11'h142, jsp_pkg::OP_READ,
                              32'd7));
        push_request(make_req(jsp_pkg::ACT_REPLY, 3'd0, 32'd0, 11'h243, jsp_pkg::OP_READ,
                              32'd9));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd0, 32'h7fffffff, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_SET, 3'd6, 32'h80000000, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_REQUEST, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
    endtask

    task automatic test_limit_extremes();
        program_limits(16'd0, 16'hffff, 7'h7f);
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
        program_limits(16'hffff, 16'd0, 7'h00);
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        push_request(make_req(jsp_pkg::ACT_REQUEST, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
        program_limits(16'hffff, 16'hffff, 7'h7f);
        push_request(make_req(jsp_pkg::ACT_TICK, 3'd0, 32'd0, 11'd0, 8'd0, 32'd0));
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        logic [6:0] mask;
        begin
            for (int phase = 0; phase < 9; phase++)
            begin
                mask = 7'($urandom_range(0, 127));
                case (phase)
                    0:       program_limits(16'd1, 16'hffff, 7'h7f);
                    1:       program_limits(16'hffff, 16'd1, mask);
                    2:       program_limits(16'd0, pick_limit(), mask);
                    3:       program_limits(16'($urandom_range(100, 4000)), pick_limit(), 7'h7f);
                    default: program_limits(pick_limit(), pick_limit(),
                                            ($urandom_range(0, 5) == 0) ? 7'h00 : mask);
                endcase
                stall_mode  = stall_mode_t'(phase % 3);
                sender_gaps = (phase != 3);
                for (int i = 0; i < 30; i++)
                begin
                    push_request(random_req());
                end
                wait_for_idle();
            end
        end
    endtask

    task automatic test_output_backpressure();
        program_limits(16'($urandom_range(1, 300)), pick_limit(), 7'h7f);
        stall_mode  = STALL_LIGHT;
        sender_gaps = 1'b0;
        holdoff_req = 400;
        for (int i = 0; i < 30; i++)
        begin
            push_request(random_req());
        end
        wait_for_idle();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = jsp_pkg::CFG_STEP_SIZE;
        cfg_data     = 16'd0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        step_sz      = jsp_pkg::STEP_SIZE_RESET;
        speed_lim    = jsp_pkg::MAX_SPEED_RESET;
        en_mask      = jsp_pkg::ENABLE_RESET;
        for (int j = 0; j < N_JOINTS; j++)
        begin
            init_ang[j] = 32'sd0;
            tgt_ang[j]  = 32'sd0;
            cur_ang[j]  = 32'sd0;
        end
        errors        = 0;
        requests_sent = 0;
        cmds_checked  = 0;
        reg_writes    = 0;
        burst_left    = 0;
        sender_gaps   = 1'b1;
        stall_mode    = STALL_LIGHT;
        holdoff_req   = 0;
        holdoff_left  = 0;
        ready_pat     = 16'hffff;
        pat_count     = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_target_conversion();
        test_reply_seeding();
        test_limit_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_for_idle();

        if (expected_cmds.size() != 0)
        begin
            report_mismatch("commands never delivered", expected_cmds.size(), 0);
        end
        $display("run covered %0d input transactions, %0d commands checked, %0d register writes",
                 requests_sent, cmds_checked, reg_writes);
        $display("directed extremes, reply seeding, random phases, long hold-off; %0d mismatches",
                 errors);
        if (errors == 0)
        begin
            $display("[joint_slew_position_commander] OK");
        end
        else
        begin
            $display("[joint_slew_position_commander] ERROR");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d commands outstanding", expected_cmds.size());
        $display("[joint_slew_position_commander] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jsp_pkg.sv
rtl/jsp_ram.sv
rtl/jsp_store.sv
rtl/jsp_arith.sv
rtl/joint_slew_position_commander.sv
rtl/jsp_checker.sv
tb/sv/tb_joint_slew_position_commander.sv
